@@ src/steepest_descent_line_search_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the steepest descent line search block
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STEEPEST_DESCENT_LINE_SEARCH_TOP_DEFINES_SVH
`define STEEPEST_DESCENT_LINE_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SDLS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdls assertion failed");
// next-cycle implication
`define SDLS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdls assertion failed");
`else
`define SDLS_ASSERT_IMP(name, ante, cons)
`define SDLS_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ src/sdls_pkg.sv @@
// ----------------------------------------------------------------------------
// sdls_pkg
// Shared types and constants of the steepest descent line search block.
// ----------------------------------------------------------------------------
package sdls_pkg;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // rejections in a row that mark the search as stuck
  localparam int unsigned MAX_REJECTS = 40;

  // floor(x/5) = (x * RECIP5) >> RECIP5_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP5       = 32'hCCCC_CCCD;
  localparam int unsigned RECIP5_SHIFT = 34;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATOM_COUNT   = 3'd0,
    CFG_INITIAL_STEP = 3'd1,
    CFG_GRAD_TOL     = 3'd2,
    CFG_ITER_LIMIT   = 3'd3,
    CFG_MIN_STEP     = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STATUS_CONTINUE   = 3'd0,
    STATUS_CONVERGED  = 3'd1,
    STATUS_ITER_LIMIT = 3'd2,
    STATUS_STUCK      = 3'd3,
    STATUS_FIRST_FAIL = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_AWAIT  = 4'b0010,
    PH_SEARCH = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
    logic signed [31:0] energy;
    logic               eval_ok;
    logic               last;
  } sdls_in_t;

  typedef struct packed {
    logic signed [31:0] trial_coord;
    logic signed [31:0] accepted_coord;
    logic               run_end;
    status_e            status;
    logic signed [31:0] best_energy;
    logic [30:0]        gradient_norm;
    logic [15:0]        moves_done;
  } sdls_out_t;

  // classified element handed from front to back
  typedef struct packed {
    logic               is_load;
    logic               in_range;
    logic               use_new;     // this run's gradient becomes the accepted one
    logic               take_trial;  // trial point accepted: coordinate moves
    logic signed [31:0] value;
    logic [31:0]        step;
    logic               run_end;
    status_e            status;
    logic signed [31:0] best_energy;
    logic [30:0]        gradient_norm;
    logic [15:0]        moves_done;
  } sdls_cmd_t;

endpackage

@@ src/steepest_descent_line_search_top.sv @@
// ----------------------------------------------------------------------------
// steepest_descent_line_search_top
// Steepest descent with backtracking line search driving an external
// energy/gradient evaluator, one coordinate element per transaction.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_ready_o  sdls_in_t  (load or evaluation)
// out       output     out_valid_o/out_ready_i  sdls_out_t (trial and accepted)
// cfg       input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One transaction per cycle sustained unless the output stalls or a store
// hazard holds; results pass queue, store read, multiply, round and saturate.
// Throughput is set by the single store port per memory and one multiplier.
// Two back-to-back transactions on the same store element (one-element runs,
// or elements past the atom count, which all map to element zero) stall the
// second in the queue while the first sits in the store-read stage.
// No clearing pass after reset; the stores are undefined until written.
// A stalled output backs up the four-entry queue, then in_ready_o drops.
// ----------------------------------------------------------------------------
module steepest_descent_line_search_top import sdls_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 64,
  localparam int unsigned MAX_ELEMS = 3 * MAX_ATOMS,
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sdls_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sdls_out_t            out_data_o
);

  localparam int unsigned Q_W = $bits(sdls_cmd_t) + ADDR_W;

  logic              take, push, full, pop, head_valid;
  sdls_cmd_t         f_cmd, h_cmd;
  logic [ADDR_W-1:0] f_idx, h_idx;
  logic [Q_W-1:0]    q_wdata, q_rdata;

  assign in_ready_o = !full;
  assign take       = in_valid_i && !full;

  // classification and control
  sdls_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .take_i    (take),
    .in_data_i (in_data_i),
    .push_o    (push),
    .cmd_o     (f_cmd),
    .idx_o     (f_idx)
  );

  // decoupling queue
  assign q_wdata      = {f_idx, f_cmd};
  assign {h_idx, h_cmd} = q_rdata;

  sdls_queue #(.DATA_W(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (q_rdata)
  );

  // stores and arithmetic
  sdls_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_cmd_i  (h_cmd),
    .head_idx_i  (h_idx),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ src/sdls_queue.sv @@
// ----------------------------------------------------------------------------
// sdls_queue
// Small register FIFO decoupling the front classifier from the back datapath.
// ----------------------------------------------------------------------------
`include "steepest_descent_line_search_top_defines.svh"

module sdls_queue import sdls_pkg::*; #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4,
  localparam int unsigned PTR_W = $clog2(DEPTH),
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o
);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SDLS_ASSERT_IMP(a_no_overflow, push_i, !full_o || pop_i)
  `SDLS_ASSERT_IMP(a_no_underflow, pop_i, valid_o)
  `SDLS_ASSERT_NXT(a_count_hold, !push_i && !pop_i, $stable(count_q))

endmodule

@@ src/sdls_front.sv @@
// ----------------------------------------------------------------------------
// sdls_front
// Configuration registers and search control: classifies each transaction,
// decides accept or reject, tracks step, energy, norm and counters.
// ----------------------------------------------------------------------------
module sdls_front import sdls_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 64,
  localparam int unsigned MAX_ELEMS = 3 * MAX_ATOMS,
  localparam int unsigned IDX_W     = $clog2(MAX_ELEMS + 1),
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 take_i,
  input  sdls_in_t             in_data_i,
  output logic                 push_o,
  output sdls_cmd_t            cmd_o,
  output logic [ADDR_W-1:0]    idx_o
);

  // configuration
  logic [6:0]  atom_count_q;
  logic [31:0] initial_step_q, min_step_q;
  logic [30:0] conv_tol_q;
  logic [15:0] iter_limit_q;

  // search state
  phase_e      phase_q, phase_d;
  logic [IDX_W-1:0] elem_idx_q, elem_idx_d;
  logic [31:0] step_q, step_d, fifth_q, fifth_d;
  logic signed [31:0] energy_q, energy_d;
  logic [30:0] norm_q, norm_d, rmax_q, rmax_d;
  logic [15:0] moves_q, moves_d;
  logic [5:0]  rejects_q, rejects_d;
  logic        run_acc_q, run_acc_d;
  status_e     fstat_q, fstat_d;

  logic [IDX_W-1:0] n_elems, cur_idx;
  logic        in_range, use_new, take_trial;
  logic [32:0] grow_sum;
  logic [31:0] grow_step, half_step;
  logic [30:0] abs_val, rmax_base;
  logic [63:0] fifth_prod;
  status_e     status;

  // element count from the atom count, clamped to the supported range
  always_comb begin
    if (atom_count_q == '0) begin
      n_elems = IDX_W'(3);
    end else if (32'(atom_count_q) > 32'(MAX_ATOMS)) begin
      n_elems = IDX_W'(MAX_ELEMS);
    end else begin
      n_elems = IDX_W'(3 * 32'(atom_count_q));
    end
  end

  // step growth by 6/5 with saturation; fifth_q holds step_q / 5
  assign grow_sum  = {1'b0, step_q} + {1'b0, fifth_q};
  assign grow_step = grow_sum[32] ? '1 : grow_sum[31:0];
  assign half_step = step_q >> 1;

  // saturated magnitude of the incoming element
  always_comb begin
    if (in_data_i.value == 32'sh8000_0000) begin
      abs_val = '1;
    end else if (in_data_i.value < 0) begin
      abs_val = 31'(-in_data_i.value);
    end else begin
      abs_val = 31'(in_data_i.value);
    end
  end

  // control update for one transaction
  always_comb begin
    phase_d    = phase_q;
    elem_idx_d = elem_idx_q;
    step_d     = step_q;
    energy_d   = energy_q;
    norm_d     = norm_q;
    rmax_d     = rmax_q;
    moves_d    = moves_q;
    rejects_d  = rejects_q;
    run_acc_d  = run_acc_q;
    fstat_d    = fstat_q;
    push_o     = 1'b0;
    status     = STATUS_CONTINUE;
    cur_idx    = elem_idx_q;
    in_range   = 1'b0;
    use_new    = 1'b0;
    take_trial = 1'b0;
    rmax_base  = rmax_q;

    if (take_i) begin
      if (in_data_i.func == FUNC_LOAD) begin
        // load restarts at element zero after any other phase
        if (phase_q != PH_IDLE) begin
          cur_idx = '0;
          phase_d = PH_IDLE;
        end
        in_range = (cur_idx < n_elems);
        push_o   = 1'b1;
        if (in_data_i.last) begin
          step_d     = initial_step_q;
          moves_d    = '0;
          rejects_d  = '0;
          fstat_d    = STATUS_CONTINUE;
          phase_d    = PH_AWAIT;
          elem_idx_d = '0;
        end else if (cur_idx < IDX_W'(MAX_ELEMS)) begin
          elem_idx_d = cur_idx + 1'b1;
        end else begin
          elem_idx_d = cur_idx;
        end
      end else if (phase_q == PH_AWAIT || phase_q == PH_SEARCH) begin
        push_o   = 1'b1;
        in_range = (cur_idx < n_elems);
        // accept or reject on the first element of the run
        if (cur_idx == '0) begin
          rmax_base = '0;
          if (phase_q == PH_AWAIT) begin
            energy_d  = in_data_i.energy;
            run_acc_d = in_data_i.eval_ok;
          end else if (in_data_i.eval_ok && (in_data_i.energy < energy_q)) begin
            run_acc_d = 1'b1;
            energy_d  = in_data_i.energy;
            step_d    = grow_step;
            moves_d   = (moves_q != '1) ? moves_q + 1'b1 : moves_q;
            rejects_d = '0;
            fstat_d   = STATUS_CONTINUE;
          end else begin
            run_acc_d = 1'b0;
            step_d    = half_step;
            rejects_d = (rejects_q != '1) ? rejects_q + 1'b1 : rejects_q;
            fstat_d   = ((32'(rejects_d) >= MAX_REJECTS) || (half_step < min_step_q))
                        ? STATUS_STUCK : STATUS_CONTINUE;
          end
        end
        use_new    = (phase_q == PH_AWAIT) || run_acc_d;
        take_trial = (phase_q == PH_SEARCH) && run_acc_d;
        rmax_d     = rmax_base;
        if (in_range && use_new && (abs_val > rmax_base)) begin
          rmax_d = abs_val;
        end
        if (in_data_i.last) begin
          if (phase_q == PH_AWAIT && !run_acc_d) begin
            status = STATUS_FIRST_FAIL;
          end else if (use_new) begin
            norm_d = rmax_d;
            if (moves_d >= iter_limit_q) begin
              status = STATUS_ITER_LIMIT;
            end else if (rmax_d < conv_tol_q) begin
              status = STATUS_CONVERGED;
            end else begin
              status = STATUS_CONTINUE;
            end
          end else begin
            status = fstat_d;
          end
          fstat_d    = status;
          phase_d    = (status != STATUS_CONTINUE) ? PH_DONE : PH_SEARCH;
          elem_idx_d = '0;
        end else if (cur_idx < IDX_W'(MAX_ELEMS)) begin
          elem_idx_d = cur_idx + 1'b1;
        end
      end
    end
  end

  // step / 5 computed from the next step and registered alongside it
  assign fifth_prod = 64'(step_d) * 64'(RECIP5);
  assign fifth_d    = 32'(fifth_prod >> RECIP5_SHIFT);

  // command to the back end
  always_comb begin
    cmd_o.is_load       = (in_data_i.func == FUNC_LOAD);
    cmd_o.in_range      = in_range;
    cmd_o.use_new       = use_new;
    cmd_o.take_trial    = take_trial;
    cmd_o.value         = in_data_i.value;
    cmd_o.step          = step_d;
    cmd_o.run_end       = in_data_i.last;
    cmd_o.status        = status;
    cmd_o.best_energy   = energy_d;
    cmd_o.gradient_norm = norm_d;
    cmd_o.moves_done    = moves_d;
    idx_o               = in_range ? cur_idx[ADDR_W-1:0] : '0;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_count_q   <= 7'd1;
      initial_step_q <= 32'd16777216;
      conv_tol_q     <= 31'd66;
      iter_limit_q   <= 16'd1000;
      min_step_q     <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ATOM_COUNT:   atom_count_q   <= cfg_data_i[6:0];
        CFG_INITIAL_STEP: initial_step_q <= cfg_data_i;
        CFG_GRAD_TOL:     conv_tol_q     <= cfg_data_i[30:0];
        CFG_ITER_LIMIT:   iter_limit_q   <= cfg_data_i[15:0];
        CFG_MIN_STEP:     min_step_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elem_idx_q <= '0;
      step_q     <= '0;
      fifth_q    <= '0;
      energy_q   <= '0;
      norm_q     <= '0;
      rmax_q     <= '0;
      moves_q    <= '0;
      rejects_q  <= '0;
      run_acc_q  <= 1'b0;
      fstat_q    <= STATUS_CONTINUE;
    end else begin
      phase_q    <= phase_d;
      elem_idx_q <= elem_idx_d;
      step_q     <= step_d;
      fifth_q    <= fifth_d;
      energy_q   <= energy_d;
      norm_q     <= norm_d;
      rmax_q     <= rmax_d;
      moves_q    <= moves_d;
      rejects_q  <= rejects_d;
      run_acc_q  <= run_acc_d;
      fstat_q    <= fstat_d;
    end
  end

endmodule

@@ src/sdls_back.sv @@
// ----------------------------------------------------------------------------
// sdls_back
// Coordinate, gradient and trial stores with the step * gradient datapath;
// three stages: store read, multiply, round/subtract/saturate into output.
// ----------------------------------------------------------------------------
module sdls_back import sdls_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 64,
  localparam int unsigned MAX_ELEMS = 3 * MAX_ATOMS,
  localparam int unsigned ADDR_W    = $clog2(MAX_ELEMS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  sdls_cmd_t         head_cmd_i,
  input  logic [ADDR_W-1:0] head_idx_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdls_out_t         out_data_o
);

  logic signed [31:0] coord_mem [MAX_ELEMS];
  logic signed [31:0] grad_mem  [MAX_ELEMS];
  logic signed [31:0] trial_mem [MAX_ELEMS];

  logic               advance, hazard;
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  sdls_cmd_t          s1_cmd_q, s2_cmd_q;
  logic [ADDR_W-1:0]  s1_idx_q, s2_idx_q;
  logic signed [31:0] coord_rd_q, grad_rd_q, trial_rd_q;
  logic signed [31:0] s2_acc_q;
  logic signed [64:0] prod_q;
  sdls_out_t          out_q;

  logic               coord_we, grad_we, trial_we;
  logic signed [31:0] coord_wd, trial_wd;
  logic signed [31:0] s1_acc, s1_grad;
  logic signed [64:0] rounded;
  logic signed [41:0] diff;

  // the whole pipe moves when the output register can take a transaction
  assign advance = !out_valid_q || out_ready_i;
  // hold the head if the stage ahead will still write this element's trial
  assign hazard  = s1_valid_q && (s1_idx_q == head_idx_i);
  assign pop_o   = head_valid_i && advance && !hazard;

  // stage 1 operand selection
  always_comb begin
    if (s1_cmd_q.is_load) begin
      s1_acc = s1_cmd_q.value;
    end else if (s1_cmd_q.take_trial) begin
      s1_acc = trial_rd_q;
    end else begin
      s1_acc = coord_rd_q;
    end
    s1_grad = s1_cmd_q.use_new ? s1_cmd_q.value : grad_rd_q;
  end

  // store writes
  assign coord_we = advance && s1_valid_q && s1_cmd_q.in_range
                    && (s1_cmd_q.is_load || s1_cmd_q.take_trial);
  assign coord_wd = s1_acc;
  assign grad_we  = advance && s1_valid_q && s1_cmd_q.in_range
                    && !s1_cmd_q.is_load && s1_cmd_q.use_new;
  assign trial_we = advance && s2_valid_q && s2_cmd_q.in_range && !s2_cmd_q.is_load;

  // trial = accepted - round(step * gradient), rounded half up, saturated
  always_comb begin
    rounded = prod_q + 65'sd8388608;
    diff    = 42'(s2_acc_q) - 42'($signed(rounded[64:24]));
    if (diff[41:31] == '0 || diff[41:31] == '1) begin
      trial_wd = diff[31:0];
    end else if (diff[41]) begin
      trial_wd = 32'sh8000_0000;
    end else begin
      trial_wd = 32'sh7FFF_FFFF;
    end
  end

  // stores, read data registered with write-first bypass
  always_ff @(posedge clk_i) begin
    if (coord_we) begin
      coord_mem[s1_idx_q] <= coord_wd;
    end
    if (grad_we) begin
      grad_mem[s1_idx_q] <= s1_cmd_q.value;
    end
    if (trial_we) begin
      trial_mem[s2_idx_q] <= trial_wd;
    end
    if (pop_o) begin
      coord_rd_q <= (coord_we && s1_idx_q == head_idx_i) ? coord_wd : coord_mem[head_idx_i];
      grad_rd_q  <= (grad_we && s1_idx_q == head_idx_i) ? s1_cmd_q.value
                                                         : grad_mem[head_idx_i];
      trial_rd_q <= (trial_we && s2_idx_q == head_idx_i) ? trial_wd : trial_mem[head_idx_i];
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cmd_q <= head_cmd_i;
      s1_idx_q <= head_idx_i;
    end
    if (advance && s1_valid_q) begin
      s2_cmd_q <= s1_cmd_q;
      s2_idx_q <= s1_idx_q;
      s2_acc_q <= s1_acc;
      prod_q   <= $signed({1'b0, s1_cmd_q.step}) * $signed({s1_grad[31], s1_grad});
    end
    if (advance && s2_valid_q) begin
      out_q.trial_coord    <= !s2_cmd_q.in_range ? '0
                              : (s2_cmd_q.is_load ? s2_acc_q : trial_wd);
      out_q.accepted_coord <= s2_cmd_q.in_range ? s2_acc_q : '0;
      out_q.run_end        <= s2_cmd_q.run_end;
      out_q.status         <= s2_cmd_q.status;
      out_q.best_energy    <= s2_cmd_q.best_energy;
      out_q.gradient_norm  <= s2_cmd_q.gradient_norm;
      out_q.moves_done     <= s2_cmd_q.moves_done;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
